// ===== src/tppf_pkg.sv =====
// Shared widths, types and constants for the three-point parabola fit.
// Used by tppf_front, tppf_div and three_point_parabola_fit; depends on nothing.
`default_nettype none

package tppf_pkg;

  // Coordinate width and output fraction bits
  localparam int unsigned CW    = 16;
  localparam int unsigned FRAC  = 16;
  localparam int unsigned NLANE = 3;

  // Intermediate widths
  localparam int unsigned DW    = CW + 1;          // coordinate difference
  localparam int unsigned PW    = 2 * CW;          // product of two coordinates
  localparam int unsigned TA_W  = CW + DW;         // x * dy
  localparam int unsigned TB_W  = PW + DW;         // x^2 * dy, x*x * dx
  localparam int unsigned TC_W  = PW + DW + CW;    // x*x * dx * y
  localparam int unsigned NUM_W = TC_W + 2;        // sum of three terms
  localparam int unsigned DEN_W = 3 * DW;          // product of three differences

  // Quotient and result widths
  localparam int unsigned OUT_W = 64;
  localparam int unsigned Q_W   = OUT_W + 1;
  localparam int unsigned N_W   = Q_W + DEN_W;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((6 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((NLANE * OUT_W + 7) / 8) * 8;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [DEN_W-1:0] den_t;
  typedef logic signed [OUT_W-1:0] coef_t;

  // Control travelling alongside the data
  typedef struct packed {
    logic valid;
    logic ok;
  } tag_t;

  // One lane of the restoring divider
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
  } lane_t;

endpackage

`default_nettype wire

// ===== src/tppf_front.sv =====
// Front pipeline: differences, products and sums giving the three numerators
// and the common denominator. Depends on tppf_pkg.
`default_nettype none

module tppf_front
  import tppf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [CW-1:0] x1_i,
  input  wire logic signed [CW-1:0] y1_i,
  input  wire logic signed [CW-1:0] x2_i,
  input  wire logic signed [CW-1:0] y2_i,
  input  wire logic signed [CW-1:0] x3_i,
  input  wire logic signed [CW-1:0] y3_i,
  output tag_t                     tag_o,
  output num_t                     num_o [NLANE],
  output den_t                     den_o
);

  // Stage 1 registers
  tag_t                    f1_tag_q;
  logic signed [DW-1:0]    f1_d12_q, f1_d13_q, f1_d23_q;
  logic signed [DW-1:0]    f1_dy21_q, f1_dy13_q, f1_dy32_q;
  logic signed [PW-1:0]    f1_sq1_q, f1_sq2_q, f1_sq3_q;
  logic signed [PW-1:0]    f1_p23_q, f1_p13_q, f1_p12_q;
  logic signed [CW-1:0]    f1_x1_q, f1_x2_q, f1_x3_q;
  logic signed [CW-1:0]    f1_y1_q, f1_y2_q, f1_y3_q;

  // Stage 2 registers
  tag_t                    f2_tag_q;
  logic signed [2*DW-1:0]  f2_den12_q;
  logic signed [DW-1:0]    f2_d23_q;
  logic signed [TA_W-1:0]  f2_ta0_q, f2_ta1_q, f2_ta2_q;
  logic signed [TB_W-1:0]  f2_tb0_q, f2_tb1_q, f2_tb2_q;
  logic signed [TB_W-1:0]  f2_tc0_q, f2_tc1_q, f2_tc2_q;
  logic signed [CW-1:0]    f2_y1_q, f2_y2_q, f2_y3_q;

  // Stage 3 registers
  tag_t                    f3_tag_q;
  den_t                    f3_den_q;
  num_t                    f3_a_q, f3_b_q;
  logic signed [TC_W-1:0]  f3_cy0_q, f3_cy1_q, f3_cy2_q;

  // Stage 4 registers
  tag_t                    f4_tag_q;
  num_t                    f4_num_q [NLANE];
  den_t                    f4_den_q;

  num_t                    c_sum;

  // Advance control through all four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_tag_q <= '0;
      f2_tag_q <= '0;
      f3_tag_q <= '0;
      f4_tag_q <= '0;
    end else if (en_i) begin
      f1_tag_q.valid <= valid_i;
      f1_tag_q.ok    <= (x1_i != x2_i) && (x2_i != x3_i) && (x1_i != x3_i);
      f2_tag_q       <= f1_tag_q;
      f3_tag_q       <= f2_tag_q;
      f4_tag_q       <= f3_tag_q;
    end
  end

  // Differences, squares and cross products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_d12_q  <= DW'(x1_i) - DW'(x2_i);
      f1_d13_q  <= DW'(x1_i) - DW'(x3_i);
      f1_d23_q  <= DW'(x2_i) - DW'(x3_i);
      f1_dy21_q <= DW'(y2_i) - DW'(y1_i);
      f1_dy13_q <= DW'(y1_i) - DW'(y3_i);
      f1_dy32_q <= DW'(y3_i) - DW'(y2_i);
      f1_sq1_q  <= PW'(x1_i) * PW'(x1_i);
      f1_sq2_q  <= PW'(x2_i) * PW'(x2_i);
      f1_sq3_q  <= PW'(x3_i) * PW'(x3_i);
      f1_p23_q  <= PW'(x2_i) * PW'(x3_i);
      f1_p13_q  <= PW'(x3_i) * PW'(x1_i);
      f1_p12_q  <= PW'(x1_i) * PW'(x2_i);
      f1_x1_q   <= x1_i;
      f1_x2_q   <= x2_i;
      f1_x3_q   <= x3_i;
      f1_y1_q   <= y1_i;
      f1_y2_q   <= y2_i;
      f1_y3_q   <= y3_i;
    end
  end

  // Second level of products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f2_den12_q <= (2*DW)'(f1_d12_q) * (2*DW)'(f1_d13_q);
      f2_d23_q   <= f1_d23_q;
      f2_ta0_q   <= TA_W'(f1_x3_q) * TA_W'(f1_dy21_q);
      f2_ta1_q   <= TA_W'(f1_x2_q) * TA_W'(f1_dy13_q);
      f2_ta2_q   <= TA_W'(f1_x1_q) * TA_W'(f1_dy32_q);
      f2_tb0_q   <= TB_W'(f1_sq3_q) * TB_W'(f1_dy21_q);
      f2_tb1_q   <= TB_W'(f1_sq2_q) * TB_W'(f1_dy13_q);
      f2_tb2_q   <= TB_W'(f1_sq1_q) * TB_W'(f1_dy32_q);
      f2_tc0_q   <= TB_W'(f1_p23_q) * TB_W'(f1_d23_q);
      f2_tc1_q   <= TB_W'(f1_p13_q) * TB_W'(f1_d13_q);
      f2_tc2_q   <= TB_W'(f1_p12_q) * TB_W'(f1_d12_q);
      f2_y1_q    <= f1_y1_q;
      f2_y2_q    <= f1_y2_q;
      f2_y3_q    <= f1_y3_q;
    end
  end

  // Denominator, a and b sums, c terms times y
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f3_den_q <= DEN_W'(f2_den12_q) * DEN_W'(f2_d23_q);
      f3_a_q   <= NUM_W'(f2_ta0_q) + NUM_W'(f2_ta1_q) + NUM_W'(f2_ta2_q);
      f3_b_q   <= -(NUM_W'(f2_tb0_q) + NUM_W'(f2_tb1_q) + NUM_W'(f2_tb2_q));
      f3_cy0_q <= TC_W'(f2_tc0_q) * TC_W'(f2_y1_q);
      f3_cy1_q <= TC_W'(f2_tc1_q) * TC_W'(f2_y2_q);
      f3_cy2_q <= TC_W'(f2_tc2_q) * TC_W'(f2_y3_q);
    end
  end

  // The middle c term carries (x3 - x1), the negation of d13
  assign c_sum = NUM_W'(f3_cy0_q) - NUM_W'(f3_cy1_q) + NUM_W'(f3_cy2_q);

  // Force a zero quotient for coincident x values
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f4_num_q[0] <= f3_tag_q.ok ? f3_a_q : '0;
      f4_num_q[1] <= f3_tag_q.ok ? f3_b_q : '0;
      f4_num_q[2] <= f3_tag_q.ok ? c_sum  : '0;
      f4_den_q    <= f3_tag_q.ok ? f3_den_q : DEN_W'(1);
    end
  end

  assign tag_o = f4_tag_q;
  assign num_o = f4_num_q;
  assign den_o = f4_den_q;

endmodule

`default_nettype wire

// ===== src/tppf_div.sv =====
// Pipelined restoring divider for three numerators over one denominator, one
// quotient bit per stage, with rounding and 64-bit saturation. Depends on tppf_pkg.
`default_nettype none

module tppf_div
  import tppf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire tag_t tag_i,
  input  wire num_t num_i [NLANE],
  input  wire den_t den_i,
  output tag_t      tag_o,
  output coef_t     coef_o [NLANE]
);

  localparam logic [Q_W:0] MAX_POS = (Q_W+1)'({(OUT_W-1){1'b1}});
  localparam logic [Q_W:0] MAX_NEG = (Q_W+1)'(1) << (OUT_W - 1);

  // Magnitude stage
  tag_t               a_tag_q;
  logic               a_neg_q  [NLANE];
  logic [NUM_W-1:0]   a_nmag_q [NLANE];
  logic [DEN_W-1:0]   a_dmag_q;

  // Step pipeline, index 0 is the set-up stage
  tag_t               s_tag_q [Q_W+1];
  logic [DEN_W-1:0]   s_d_q   [Q_W+1];
  lane_t              s_ln_q  [Q_W+1][NLANE];

  // Rounding and saturation stages
  tag_t               r_tag_q;
  logic               r_neg_q [NLANE];
  logic               r_ovf_q [NLANE];
  logic [Q_W:0]       r_q_q   [NLANE];
  tag_t               o_tag_q;
  coef_t              o_coef_q [NLANE];

  // Take magnitudes and the result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dmag_q <= den_i[DEN_W-1] ? DEN_W'($unsigned(-den_i)) : DEN_W'($unsigned(den_i));
      for (int l = 0; l < NLANE; l++) begin
        a_neg_q[l]  <= num_i[l][NUM_W-1] ^ den_i[DEN_W-1];
        a_nmag_q[l] <= num_i[l][NUM_W-1] ? NUM_W'($unsigned(-num_i[l]))
                                         : NUM_W'($unsigned(num_i[l]));
      end
    end
  end

  // Scale the numerator and test the top part for overflow
  always_ff @(posedge clk_i) begin
    logic [N_W-1:0] nfull;
    if (en_i) begin
      s_d_q[0] <= a_dmag_q;
      for (int l = 0; l < NLANE; l++) begin
        nfull = N_W'(a_nmag_q[l]) << FRAC;
        s_ln_q[0][l].neg <= a_neg_q[l];
        s_ln_q[0][l].ovf <= nfull[N_W-1:Q_W] >= a_dmag_q;
        s_ln_q[0][l].rem <= (nfull[N_W-1:Q_W] >= a_dmag_q) ? '0 : nfull[N_W-1:Q_W];
        s_ln_q[0][l].nlo <= nfull[Q_W-1:0];
        s_ln_q[0][l].q   <= '0;
      end
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic [DEN_W:0] r2;
      logic           ge;
      lane_t          nxt;

      assign r2 = {s_ln_q[k][l].rem, s_ln_q[k][l].nlo[Q_W-1-k]};
      assign ge = r2 >= {1'b0, s_d_q[k]};

      always_comb begin
        nxt     = s_ln_q[k][l];
        nxt.rem = ge ? DEN_W'(r2 - {1'b0, s_d_q[k]}) : DEN_W'(r2);
        nxt.q   = {s_ln_q[k][l].q[Q_W-2:0], ge};
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_ln_q[k+1][l] <= nxt;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_d_q[k+1] <= s_d_q[k];
      end
    end
  end

  // Round half away from zero on the magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NLANE; l++) begin
        r_neg_q[l] <= s_ln_q[Q_W][l].neg;
        r_ovf_q[l] <= s_ln_q[Q_W][l].ovf;
        r_q_q[l]   <= (Q_W+1)'(s_ln_q[Q_W][l].q)
                    + (Q_W+1)'({s_ln_q[Q_W][l].rem, 1'b0} >= {1'b0, s_d_q[Q_W]});
      end
    end
  end

  // Saturate and apply the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NLANE; l++) begin
        if (!r_neg_q[l]) begin
          o_coef_q[l] <= (r_ovf_q[l] || r_q_q[l] > MAX_POS) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                            : OUT_W'(r_q_q[l]);
        end else begin
          o_coef_q[l] <= (r_ovf_q[l] || r_q_q[l] > MAX_NEG) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                            : OUT_W'(-r_q_q[l]);
        end
      end
    end
  end

  // Control travels with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      for (int k = 0; k <= Q_W; k++) begin
        s_tag_q[k] <= '0;
      end
      r_tag_q <= '0;
      o_tag_q <= '0;
    end else if (en_i) begin
      a_tag_q    <= tag_i;
      s_tag_q[0] <= a_tag_q;
      for (int k = 0; k < Q_W; k++) begin
        s_tag_q[k+1] <= s_tag_q[k];
      end
      r_tag_q <= s_tag_q[Q_W];
      o_tag_q <= r_tag_q;
    end
  end

  assign tag_o  = o_tag_q;
  assign coef_o = o_coef_q;

endmodule

`default_nettype wire

// ===== src/three_point_parabola_fit.sv =====
// Top level of the three-point parabola fit: stream ports, front pipeline,
// divider pipeline and output register with skid stage. Depends on tppf_pkg.
`default_nettype none

// Fits y = a*x^2 + b*x + c through three points and returns a, b and c as
// signed fixed point with 16 fraction bits, rounded to nearest (ties away
// from zero) and saturated to 64 bits. One request is accepted every clock
// cycle while the skid stage is empty. The register stages are: a four-stage
// multiply front end, then the divider with a magnitude stage, a set-up stage,
// 65 restoring stages yielding one quotient bit each, a rounding stage and a
// saturation stage, and finally the output register. If two x values are
// equal, tuser is 0 and all coefficients are zero. A skid stage behind the
// output register lets input continue while a result waits; tready falls only
// once that stage is full.
module three_point_parabola_fit
  import tppf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // coef_square, coef_linear, coef_const
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // fit_ok
  output logic                       m_axis_tuser
);

  logic                   en;
  tag_t                   fr_tag;
  num_t                   fr_num [NLANE];
  den_t                   fr_den;
  tag_t                   dv_tag;
  coef_t                  dv_coef [NLANE];
  logic [OUT_DATA_W-1:0]  dv_data;

  logic                   out_valid_q;
  logic                   out_ok_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   skid_valid_q;
  logic                   skid_ok_q;
  logic [OUT_DATA_W-1:0]  skid_data_q;

  logic                   take;
  logic                   fresh;

  // The whole pipeline moves while the skid stage is empty
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  tppf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x1_i    ($signed(s_axis_tdata[CW-1:0])),
    .y1_i    ($signed(s_axis_tdata[2*CW-1:CW])),
    .x2_i    ($signed(s_axis_tdata[3*CW-1:2*CW])),
    .y2_i    ($signed(s_axis_tdata[4*CW-1:3*CW])),
    .x3_i    ($signed(s_axis_tdata[5*CW-1:4*CW])),
    .y3_i    ($signed(s_axis_tdata[6*CW-1:5*CW])),
    .tag_o   (fr_tag),
    .num_o   (fr_num),
    .den_o   (fr_den)
  );

  tppf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (fr_tag),
    .num_i  (fr_num),
    .den_i  (fr_den),
    .tag_o  (dv_tag),
    .coef_o (dv_coef)
  );

  assign dv_data = OUT_DATA_W'({dv_coef[2], dv_coef[1], dv_coef[0]});
  assign take    = out_valid_q && m_axis_tready;
  assign fresh   = en && dv_tag.valid;

  // Output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (fresh) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register and skid stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
        out_ok_q   <= skid_ok_q;
      end
    end else if (fresh) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_data_q <= dv_data;
        skid_ok_q   <= dv_tag.ok;
      end else begin
        out_data_q <= dv_data;
        out_ok_q   <= dv_tag.ok;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  // A waiting result in the skid stage always has one ahead of it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result with the output register empty");

  // The skid stage fills only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid stage loaded while the output was free");

  // A failed fit carries zero coefficients
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("coincident x values gave nonzero coefficients");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for three_point_parabola_fit: random and directed point
// triples, exact rational prediction and a scoreboard. Depends on tppf_pkg.
`timescale 1ns / 1ps

typedef logic signed [255:0] wide_t;

typedef struct {
  logic  ok;
  logic signed [63:0] sq;
  logic signed [63:0] lin;
  logic signed [63:0] cst;
} fit_t;

class fit_scoreboard;
  fit_t pending[$];
  int   errors;

  // Round num * 2^16 / den to nearest, ties away from zero, saturate to 64 bits
  static function logic signed [63:0] fixed_ratio(wide_t num, wide_t den);
    wide_t n, d, q, r;
    logic  neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n <<< 16;
    q = n / d;
    r = n % d;
    if ((r <<< 1) >= d) q = q + 1;
    if (neg) begin
      if (q > (wide_t'(1) <<< 63)) return 64'sh8000_0000_0000_0000;
      return 64'(-q);
    end
    if (q > (wide_t'(1) <<< 63) - 1) return 64'sh7fff_ffff_ffff_ffff;
    return 64'(q);
  endfunction

  // Work out the coefficients of the parabola through three points
  function void note_request(logic [95:0] pts);
    wide_t x1, y1, x2, y2, x3, y3, den, num;
    fit_t  f;
    x1 = $signed(pts[15:0]);  y1 = $signed(pts[31:16]);
    x2 = $signed(pts[47:32]); y2 = $signed(pts[63:48]);
    x3 = $signed(pts[79:64]); y3 = $signed(pts[95:80]);
    f = '{ok: 1'b0, sq: 64'sd0, lin: 64'sd0, cst: 64'sd0};
    if (x1 != x2 && x2 != x3 && x1 != x3) begin
      f.ok = 1'b1;
      den = (x1 - x2) * (x1 - x3) * (x2 - x3);
      num = x3 * (y2 - y1) + x2 * (y1 - y3) + x1 * (y3 - y2);
      f.sq = fixed_ratio(num, den);
      num = x3 * x3 * (y1 - y2) + x2 * x2 * (y3 - y1) + x1 * x1 * (y2 - y3);
      f.lin = fixed_ratio(num, den);
      num = x2 * x3 * (x2 - x3) * y1 + x3 * x1 * (x3 - x1) * y2
          + x1 * x2 * (x1 - x2) * y3;
      f.cst = fixed_ratio(num, den);
    end
    pending.push_back(f);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  // Compare one result against the oldest expectation
  task check_result(logic ok, logic [191:0] data);
    fit_t f;
    if (pending.size() == 0) begin
      report("unexpected result", data[63:0], 64'd0);
      return;
    end
    f = pending.pop_front();
    if (ok !== f.ok) report("fit_ok", 64'(ok), 64'(f.ok));
    if (data[63:0] !== f.sq) report("coef_square", data[63:0], f.sq);
    if (data[127:64] !== f.lin) report("coef_linear", data[127:64], f.lin);
    if (data[191:128] !== f.cst) report("coef_const", data[191:128], f.cst);
  endtask
endclass

module tb;
  import tppf_pkg::*;

  localparam int LIMIT = 300000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  fit_scoreboard sb = new();
  int send_idle = 13, recv_idle = 73;
  logic hold_off = 1'b0;
  int cycles = 0;

  three_point_parabola_fit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("three_point_parabola_fit regression: fail");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);

  // Receiver back-pressure
  always @(negedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

  // Offer one request, with a random gap first, and wait for it to be taken
  task send_points(logic [95:0] pts);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(pts);
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_request(pts);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] coord(bit narrow);
    if (narrow) return 16'($signed($urandom_range(20)) - 10);
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly distinct x; sometimes a deliberate collision
  task send_random();
    logic [15:0] c[6];
    bit narrow;
    narrow = $urandom_range(2) == 0;
    foreach (c[i]) c[i] = coord(narrow);
    case ($urandom_range(15))
      0: c[2] = c[0];
      1: c[4] = c[2];
      2: c[4] = c[0];
      default: ;
    endcase
    send_points({c[5], c[4], c[3], c[2], c[1], c[0]});
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, each pair of equal x, exact and tie cases
    send_points({16'h7fff, 16'h7fff, 16'h8000, 16'h8001, 16'h7fff, 16'h8000});
    send_points({16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h8000, 16'h7fff});
    send_points({16'h7fff, 16'h0000, 16'h8000, 16'h0001, 16'h0000, 16'h8000});
    send_points({16'h8000, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h8000, 16'h8000});
    send_points({16'h0003, 16'h0002, 16'h0004, 16'h0005, 16'h0006, 16'h0005});
    send_points({16'h0003, 16'h0002, 16'h0004, 16'h0002, 16'h0006, 16'h0001});
    send_points({16'h0003, 16'h0002, 16'h0004, 16'h0001, 16'h0006, 16'h0002});
    send_points({16'h0009, 16'h0002, 16'h0004, 16'h0001, 16'h0001, 16'h0000});
    send_points({16'h0001, 16'h0003, 16'h0001, 16'h0002, 16'h0001, 16'h0001});
    send_points({16'h0000, 16'h0001, 16'h0000, 16'hffff, 16'h0000, 16'h0000});
    send_points({16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hffff});
    send_points({16'h0001, 16'h7fff, 16'h0000, 16'h7ffe, 16'h0000, 16'h7fff});
    send_points({16'h0000, 16'h0002, 16'h0000, 16'h0001, 16'hffff, 16'h0000});
    send_points({16'hffff, 16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
    send_points({16'hffff, 16'h0000, 16'h7fff, 16'h0001, 16'h8000, 16'hffff});

    // Random, in three idling phases
    repeat (180) send_random();
    send_idle = 73; recv_idle = 13;
    repeat (180) send_random();
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (190) send_random();
    s_axis_tvalid <= 1'b0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("three_point_parabola_fit regression: pass");
    else $display("three_point_parabola_fit regression: fail");
    $finish;
  end
endmodule
